FILE: rtl/upa_pkg.sv
// Shared constants, types and the exponential table of the pixel attenuation block.
package upa_pkg;

    localparam int BANDS = 13;
    localparam int CHANNELS = 3;
    localparam int COLORS = 3;
    localparam int SUM_W = 33 + $clog2(BANDS + 1);

    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_LOAD_ATT = 2'd1;
    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd2;

    localparam logic [2:0] REG_GAIN_BLUE = 3'd0;
    localparam logic [2:0] REG_GAIN_GREEN = 3'd1;
    localparam logic [2:0] REG_GAIN_RED = 3'd2;
    localparam logic [2:0] REG_BIAS_BLUE = 3'd3;
    localparam logic [2:0] REG_BIAS_GREEN = 3'd4;
    localparam logic [2:0] REG_BIAS_RED = 3'd5;

    typedef logic [16:0] exp_rom_t [0:256];

    typedef struct packed {
        logic                               valid;
        logic [15:0]                        depth;
        logic [CHANNELS-1:0][SUM_W-1:0]     sum;
    } token_t;

    typedef struct packed {
        logic                beta_we;
        logic [CHANNELS-1:0] w_we;
        logic [15:0]         data;
    } cell_wr_t;

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] p;
        term = 64'd1 << 30;
        ratio = term;
        p = term;
        for (int n = 1; n <= 6; n++) begin
            term = term / 64'(16 * n);
            if (n % 2 == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        rom[0] = 17'((p + (64'd1 << 13)) >> 14);
        for (int k = 1; k <= 256; k++) begin
            p = (p * ratio + (64'd1 << 29)) >> 30;
            rom[k] = 17'((p + (64'd1 << 13)) >> 14);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: rtl/upa_cell.sv
// One band cell: holds a band's attenuation and weights and adds its term to the running sums.
module upa_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  upa_pkg::cell_wr_t  wr,
    input  upa_pkg::token_t    tok_in,
    output upa_pkg::token_t    tok_out
);

    logic [15:0]                         beta_reg;
    logic [upa_pkg::CHANNELS-1:0][15:0]  w_reg;

    logic                                v1_reg, v2_reg, v3_reg;
    logic [15:0]                         d1_reg, d2_reg, d3_reg;
    logic [upa_pkg::CHANNELS-1:0][upa_pkg::SUM_W-1:0] s1_reg, s2_reg, s3_reg;
    logic [15:0]                         a_reg;
    logic [16:0]                         e_reg;

    logic [31:0] a_prod;
    logic [16:0] hi, lo, diff;
    logic [24:0] slope;
    logic [16:0] e_next;

    always_ff @(posedge aclk) begin
        if (wr.beta_we) begin
            beta_reg <= wr.data;
        end
        for (int c = 0; c < upa_pkg::CHANNELS; c++) begin
            if (wr.w_we[c]) begin
                w_reg[c] <= wr.data;
            end
        end
    end

    assign a_prod = beta_reg * tok_in.depth;

    always_comb begin
        hi = upa_pkg::EXP_ROM[{1'b0, a_reg[15:8]}];
        lo = upa_pkg::EXP_ROM[9'({1'b0, a_reg[15:8]} + 9'd1)];
        diff = (hi >= lo) ? (hi - lo) : 17'd0;
        slope = diff * a_reg[7:0];
        e_next = hi - 17'(slope >> 8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= tok_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d1_reg <= tok_in.depth;
        s1_reg <= tok_in.sum;
        a_reg <= a_prod[31:16];
        d2_reg <= d1_reg;
        s2_reg <= s1_reg;
        e_reg <= e_next;
        d3_reg <= d2_reg;
        for (int c = 0; c < upa_pkg::CHANNELS; c++) begin
            s3_reg[c] <= s2_reg[c] + upa_pkg::SUM_W'(w_reg[c] * e_reg);
        end
    end

    assign tok_out.valid = v3_reg;
    assign tok_out.depth = d3_reg;
    assign tok_out.sum = s3_reg;

endmodule

FILE: rtl/upa_shade.sv
// Per-color blend of the direct and backscatter parts into one saturated 8-bit intensity.
module upa_shade (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [16:0] trans,
    input  logic [7:0]  pix,
    input  logic [16:0] gain,
    input  logic [15:0] bias,
    output logic        out_valid,
    output logic [7:0]  out_pix
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [24:0] pg_reg;
    logic [16:0] t_reg, nt_reg;
    logic [15:0] b_reg;
    logic [41:0] direct_reg;
    logic [32:0] back_reg;
    logic [7:0]  out_reg;
    logic [42:0] num;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign num = 43'(direct_reg) + {2'b0, back_reg, 8'b0};

    always_ff @(posedge aclk) begin
        pg_reg <= pix * gain;
        t_reg <= trans;
        nt_reg <= 17'h10000 - trans;
        b_reg <= bias;
        direct_reg <= pg_reg * t_reg;
        back_reg <= b_reg * nt_reg;
        out_reg <= (num[42:32] > 11'd255) ? 8'hFF : num[39:32];
    end

    assign out_valid = v3_reg;
    assign out_pix = out_reg;

endmodule

FILE: rtl/underwater_pixel_attenuation_top.sv
// Top level of the underwater pixel attenuation block.
// Items are taken one at a time. A table load is done in the cycle it is accepted. A pixel
// item runs through a chain of band cells, then the blend, and the next item can be accepted
// in the cycle its result is shown. A result that finds the output register still full waits
// in a second register and holds off the input until it moves.
module underwater_pixel_attenuation_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [1:0]  s_channel_sel,
    input  logic [3:0]  s_band_index,
    input  logic [15:0] s_table_word,
    input  logic [7:0]  s_pix_blue,
    input  logic [7:0]  s_pix_green,
    input  logic [7:0]  s_pix_red,
    input  logic [15:0] s_depth_q,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_blue,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_red
);

    logic [upa_pkg::COLORS-1:0][16:0] gain_reg;
    logic [upa_pkg::COLORS-1:0][15:0] bias_reg;
    logic                             busy_reg, busy_next;
    logic                             start_reg;
    logic [15:0]                      depth_reg;
    logic [upa_pkg::COLORS-1:0][7:0]  pix_reg;
    logic                             pend_reg, pend_next;
    logic [upa_pkg::COLORS-1:0][7:0]  pend_pix_reg;
    logic                             m_valid_reg, m_valid_next;
    logic [upa_pkg::COLORS-1:0][7:0]  m_pix_reg;

    upa_pkg::token_t  tok [0:upa_pkg::BANDS];
    upa_pkg::cell_wr_t wr [0:upa_pkg::BANDS-1];

    logic [upa_pkg::COLORS-1:0][16:0] trans;
    logic [upa_pkg::COLORS-1:0]       sh_valid;
    logic [upa_pkg::COLORS-1:0][7:0]  sh_pix;

    logic accept, pix_accept, res_ready, load_new, load_pend, wr_cfg;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < upa_pkg::COLORS; c++) begin
                gain_reg[c] <= 17'h10000;
                bias_reg[c] <= 16'd0;
            end
        end else if (wr_cfg) begin
            unique case (paddr[4:2])
                upa_pkg::REG_GAIN_BLUE:  gain_reg[0] <= pwdata[16:0];
                upa_pkg::REG_GAIN_GREEN: gain_reg[1] <= pwdata[16:0];
                upa_pkg::REG_GAIN_RED:   gain_reg[2] <= pwdata[16:0];
                upa_pkg::REG_BIAS_BLUE:  bias_reg[0] <= pwdata[15:0];
                upa_pkg::REG_BIAS_GREEN: bias_reg[1] <= pwdata[15:0];
                upa_pkg::REG_BIAS_RED:   bias_reg[2] <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            upa_pkg::REG_GAIN_BLUE:  prdata = 32'(gain_reg[0]);
            upa_pkg::REG_GAIN_GREEN: prdata = 32'(gain_reg[1]);
            upa_pkg::REG_GAIN_RED:   prdata = 32'(gain_reg[2]);
            upa_pkg::REG_BIAS_BLUE:  prdata = 32'(bias_reg[0]);
            upa_pkg::REG_BIAS_GREEN: prdata = 32'(bias_reg[1]);
            upa_pkg::REG_BIAS_RED:   prdata = 32'(bias_reg[2]);
            default:                 prdata = 32'd0;
        endcase
    end

    assign s_ready = !busy_reg;
    assign accept = s_valid && s_ready;
    assign pix_accept = accept && (s_opcode == upa_pkg::OP_PIXEL);

    for (genvar b = 0; b < upa_pkg::BANDS; b++) begin : g_wr
        always_comb begin
            wr[b].data = s_table_word;
            wr[b].beta_we = accept && (s_opcode == upa_pkg::OP_LOAD_ATT)
                && (6'(s_band_index) == 6'(b));
            for (int c = 0; c < upa_pkg::CHANNELS; c++) begin
                wr[b].w_we[c] = accept && (s_opcode == upa_pkg::OP_LOAD_WEIGHT)
                    && (6'(s_band_index) == 6'(b)) && (3'(s_channel_sel) == 3'(c));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b0;
        end else begin
            start_reg <= pix_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            depth_reg <= s_depth_q;
            pix_reg[0] <= s_pix_blue;
            pix_reg[1] <= s_pix_green;
            pix_reg[2] <= s_pix_red;
        end
    end

    assign tok[0].valid = start_reg;
    assign tok[0].depth = depth_reg;
    assign tok[0].sum = '0;

    for (genvar b = 0; b < upa_pkg::BANDS; b++) begin : g_cell
        upa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr      (wr[b]),
            .tok_in  (tok[b]),
            .tok_out (tok[b+1])
        );
    end

    for (genvar c = 0; c < upa_pkg::COLORS; c++) begin : g_color
        if (c < upa_pkg::CHANNELS) begin : g_tab
            logic [upa_pkg::SUM_W-17:0] hi_sum;
            assign hi_sum = tok[upa_pkg::BANDS].sum[c][upa_pkg::SUM_W-1:16];
            assign trans[c] = (hi_sum > (upa_pkg::SUM_W-16)'(17'h10000))
                ? 17'h10000 : hi_sum[16:0];
        end else begin : g_full
            assign trans[c] = 17'h10000;
        end

        upa_shade u_shade (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (tok[upa_pkg::BANDS].valid),
            .trans     (trans[c]),
            .pix       (pix_reg[c]),
            .gain      (gain_reg[c]),
            .bias      (bias_reg[c]),
            .out_valid (sh_valid[c]),
            .out_pix   (sh_pix[c])
        );
    end

    assign res_ready = !m_valid_reg || m_ready;
    assign load_pend = pend_reg && res_ready;
    assign load_new = sh_valid[0] && res_ready && !pend_reg;

    always_comb begin
        busy_next = busy_reg;
        pend_next = pend_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pix_accept) begin
            busy_next = 1'b1;
        end
        if (load_pend || load_new) begin
            m_valid_next = 1'b1;
            busy_next = 1'b0;
            pend_next = 1'b0;
        end else if (sh_valid[0]) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pend_reg <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sh_valid[0] && !load_new) begin
            pend_pix_reg <= sh_pix;
        end
        if (load_pend) begin
            m_pix_reg <= pend_pix_reg;
        end else if (load_new) begin
            m_pix_reg <= sh_pix;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_blue = m_pix_reg[0];
    assign m_out_green = m_pix_reg[1];
    assign m_out_red = m_pix_reg[2];

endmodule

FILE: rtl/upa_checker.sv
// Port-level checks of the pixel attenuation block and their binding to the top level.
module upa_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_opcode,
    input logic       m_valid,
    input logic       m_ready
);

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

    a_busy_after_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == upa_pkg::OP_PIXEL) |=> !s_ready)
        else $error("pixel item accepted while another was in flight");

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result withdrawn before it was taken");

endmodule

bind underwater_pixel_attenuation_top upa_checker u_upa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_opcode (s_opcode),
    .m_valid  (m_valid),
    .m_ready  (m_ready)
);

FILE: dv/tb.sv
// Self-checking testbench of the underwater pixel attenuation block with its own predictor.
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = upa_pkg::OP_PIXEL;
    logic [1:0]  s_channel_sel = '0;
    logic [3:0]  s_band_index = '0;
    logic [15:0] s_table_word = '0;
    logic [7:0]  s_pix_blue = '0;
    logic [7:0]  s_pix_green = '0;
    logic [7:0]  s_pix_red = '0;
    logic [15:0] s_depth_q = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_blue;
    logic [7:0]  m_out_green;
    logic [7:0]  m_out_red;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic [16:0] exp_table [0:256];
    logic [15:0] beta_mem [0:upa_pkg::BANDS-1];
    logic [15:0] weight_mem [0:upa_pkg::CHANNELS-1][0:upa_pkg::BANDS-1];
    logic [16:0] gain_q [0:2];
    logic [15:0] bias_q [0:2];
    color_t      pending_colors [$];
    int          errors = 0;
    bit          idle_en = 1'b1;
    int          stall_left = 0;

    always #5 aclk = ~aclk;

    underwater_pixel_attenuation_top u_dut (.*);

    function automatic void make_exp_table();
        logic [63:0] term;
        logic [63:0] ratio;
        logic [63:0] p;
        term = 64'd1 << 30;
        ratio = term;
        p = term;
        for (int n = 1; n <= 6; n++) begin
            term = term / 64'(16 * n);
            ratio = (n & 1) ? ratio - term : ratio + term;
        end
        exp_table[0] = 17'((p + 64'd8192) >> 14);
        for (int k = 1; k <= 256; k++) begin
            p = (p * ratio + (64'd1 << 29)) >> 30;
            exp_table[k] = 17'((p + 64'd8192) >> 14);
        end
    endfunction

    function automatic logic [63:0] decay(logic [31:0] a);
        logic [31:0] k;
        logic [31:0] f;
        logic [31:0] d;
        k = (a >> 8) & 32'd255;
        f = a & 32'd255;
        d = (exp_table[k] >= exp_table[k+1]) ? exp_table[k] - exp_table[k+1] : 0;
        return 64'(exp_table[k] - ((d * f) >> 8));
    endfunction

    function automatic logic [7:0] shade_color(logic [7:0] pix, int ch, logic [15:0] depth);
        logic [63:0] acc;
        logic [63:0] t;
        logic [63:0] v;
        acc = 0;
        for (int b = 0; b < upa_pkg::BANDS; b++) begin
            acc += 64'(weight_mem[ch][b]) * decay((32'(beta_mem[b]) * 32'(depth)) >> 16);
        end
        t = acc >> 16;
        if (t > 64'd65536) t = 64'd65536;
        v = (64'(pix) * 64'(gain_q[ch]) * t + ((64'(bias_q[ch]) * (64'd65536 - t)) << 8)) >> 32;
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    task automatic send_item(logic [1:0] op, logic [1:0] ch, logic [3:0] band,
                             logic [15:0] word, logic [7:0] pb, logic [7:0] pg,
                             logic [7:0] pr, logic [15:0] depth);
        int gap;
        color_t c;
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_channel_sel <= ch;
        s_band_index <= band;
        s_table_word <= word;
        s_pix_blue <= pb;
        s_pix_green <= pg;
        s_pix_red <= pr;
        s_depth_q <= depth;
        do @(posedge aclk); while (!s_ready);
        if (op == upa_pkg::OP_LOAD_ATT) begin
            if (band < upa_pkg::BANDS) beta_mem[band] = word;
        end else if (op == upa_pkg::OP_LOAD_WEIGHT) begin
            if (band < upa_pkg::BANDS && ch < upa_pkg::CHANNELS) weight_mem[ch][band] = word;
        end else if (op == upa_pkg::OP_PIXEL) begin
            c.blue = shade_color(pb, 0, depth);
            c.green = shade_color(pg, 1, depth);
            c.red = shade_color(pr, 2, depth);
            pending_colors.push_back(c);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_colors.size() == 0);
        repeat (3 * upa_pkg::BANDS + 10) @(posedge aclk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx < 3) gain_q[idx] = val[16:0];
        else bias_q[idx - 3] = val[15:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_all(logic [31:0] g, logic [31:0] bz);
        reg_write(upa_pkg::REG_GAIN_BLUE, g);
        reg_write(upa_pkg::REG_GAIN_GREEN, g);
        reg_write(upa_pkg::REG_GAIN_RED, g);
        reg_write(upa_pkg::REG_BIAS_BLUE, bz);
        reg_write(upa_pkg::REG_BIAS_GREEN, bz);
        reg_write(upa_pkg::REG_BIAS_RED, bz);
    endtask

    task automatic load_tables(int wmax);
        for (int b = 0; b < upa_pkg::BANDS; b++) begin
            send_item(upa_pkg::OP_LOAD_ATT, 0, 4'(b), 16'($urandom_range(0, 65535)),
                      0, 0, 0, 0);
            for (int c = 0; c < upa_pkg::CHANNELS; c++)
                send_item(upa_pkg::OP_LOAD_WEIGHT, 2'(c), 4'(b),
                          16'($urandom_range(0, wmax)), 0, 0, 0, 0);
        end
    endtask

    task automatic random_pixel();
        send_item(upa_pkg::OP_PIXEL, 2'($urandom), 4'($urandom), 16'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        load_tables(5041);
        send_item(upa_pkg::OP_LOAD_ATT, 0, 4'd0, 16'd0, 0, 0, 0, 0);
        send_item(upa_pkg::OP_LOAD_ATT, 0, 4'd1, 16'hFFFF, 0, 0, 0, 0);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd0, 8'd0, 8'd0, 16'd0);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd255, 8'd255, 8'd255, 16'd0);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd255, 8'd128, 8'd1, 16'hFFFF);
        send_item(upa_pkg::OP_LOAD_ATT, 0, 4'd13, 16'h1234, 0, 0, 0, 0);
        send_item(upa_pkg::OP_LOAD_ATT, 0, 4'd15, 16'hFFFF, 0, 0, 0, 0);
        send_item(upa_pkg::OP_LOAD_WEIGHT, 2'd3, 4'd2, 16'hFFFF, 0, 0, 0, 0);
        send_item(upa_pkg::OP_LOAD_WEIGHT, 2'd1, 4'd14, 16'hFFFF, 0, 0, 0, 0);
        send_item(OP_UNUSED, 2'd3, 4'd15, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd200, 8'd100, 8'd50, 16'h1000);
        for (int b = 0; b < 6; b++)
            send_item(upa_pkg::OP_LOAD_WEIGHT, 2'd2, 4'(b), 16'hFFFF, 0, 0, 0, 0);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd255, 8'd255, 8'd255, 16'd0);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd10, 8'd20, 8'd30, 16'h8000);
        drain();
    endtask

    task automatic test_config_extremes();
        set_all(32'd0, 32'd65280);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd255, 8'd255, 8'd255, 16'h0400);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd0, 8'd0, 8'd0, 16'hFFFF);
        drain();
        set_all(32'h1FFFF, 32'd0);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd255, 8'd128, 8'd3, 16'd0);
        send_item(upa_pkg::OP_PIXEL, 0, 0, 0, 8'd77, 8'd200, 8'd255, 16'h2000);
        drain();
    endtask

    task automatic test_random(int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                random_pixel();
            end else if (sel < 82) begin
                send_item(upa_pkg::OP_LOAD_ATT, 2'($urandom), 4'($urandom_range(0, 15)),
                          16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom));
            end else if (sel < 95) begin
                send_item(upa_pkg::OP_LOAD_WEIGHT, 2'($urandom), 4'($urandom_range(0, 15)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 8000)),
                          8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
            end else begin
                send_item(OP_UNUSED, 2'($urandom), 4'($urandom), 16'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
            end
        end
        drain();
    endtask

    task automatic test_phases();
        reg_write(upa_pkg::REG_GAIN_BLUE, $urandom_range(0, 65536));
        reg_write(upa_pkg::REG_GAIN_GREEN, $urandom_range(0, 65536));
        reg_write(upa_pkg::REG_GAIN_RED, $urandom_range(0, 65536));
        reg_write(upa_pkg::REG_BIAS_BLUE, $urandom_range(0, 65280));
        reg_write(upa_pkg::REG_BIAS_GREEN, $urandom_range(0, 65280));
        reg_write(upa_pkg::REG_BIAS_RED, $urandom_range(0, 65280));
        test_random(450);
        set_all(32'd65536, 32'd0);
        test_random(450);
        set_all(32'd40000, 32'd30000);
        idle_en = 1'b0;
        test_random(400);
    endtask

    always @(negedge aclk) begin
        if (!idle_en) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        color_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (pending_colors.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result %0d %0d %0d",
                                           m_out_blue, m_out_green, m_out_red);
            end else begin
                exp_c = pending_colors.pop_front();
                if (exp_c.blue !== m_out_blue || exp_c.green !== m_out_green ||
                    exp_c.red !== m_out_red) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 exp_c.blue, exp_c.green, exp_c.red,
                                 m_out_blue, m_out_green, m_out_red);
                end
            end
        end
    end

    initial begin
        make_exp_table();
        for (int c = 0; c < 3; c++) begin
            gain_q[c] = 17'd65536;
            bias_q[c] = 16'd0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (3 * upa_pkg::BANDS + 10) @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_phases();
        if (pending_colors.size() != 0) errors++;
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
